// ----- rtl/core/tps_pkg.sv -----
// Shared types and constants of the tile palette selector.
package tps_pkg;

	localparam int COLOR_W             = 32;
	localparam int CFG_DATA_W          = 64;
	localparam int EXPL_W              = 3;
	localparam int GROUP_IDX_W         = 2;
	localparam int NUM_GROUPS_DEF      = 4;
	localparam int COLORS_PER_GROUP_DEF = 4;

	localparam logic signed [EXPL_W-1:0] EXPLICIT_AUTO = -3'sd1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_NONE    = 2'd2,
		ST_AMBIG   = 2'd3
	} status_t;

	typedef struct packed {
		logic [GROUP_IDX_W-1:0] group_index;
		status_t                status;
	} tps_result_t;

endpackage

// ----- rtl/core/tps_match.sv -----
// Per-pixel palette match: cover bits and pair conflicts of one colour.
module tps_match #(
	parameter int NUM_GROUPS       = tps_pkg::NUM_GROUPS_DEF,
	parameter int COLORS_PER_GROUP = tps_pkg::COLORS_PER_GROUP_DEF
) (
	input  logic [NUM_GROUPS-1:0][COLORS_PER_GROUP-1:0][tps_pkg::COLOR_W-1:0] palette,
	input  logic [tps_pkg::COLOR_W-1:0]                                       color,
	output logic [NUM_GROUPS-1:0]                                             covers,
	output logic [NUM_GROUPS*NUM_GROUPS-1:0]                                  conflict
);
	import tps_pkg::*;

	logic [NUM_GROUPS-1:0][COLORS_PER_GROUP-1:0] eq;
	logic [NUM_GROUPS-1:0][COLORS_PER_GROUP-1:0] first;

	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			for (int s = 0; s < COLORS_PER_GROUP; s++) begin
				eq[g][s] = (palette[g][s] == color);
			end
		end
	end

	// keep only the lowest matching slot of each group
	always_comb begin
		logic seen;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			seen = 1'b0;
			for (int s = 0; s < COLORS_PER_GROUP; s++) begin
				first[g][s] = eq[g][s] && !seen;
				seen = seen | eq[g][s];
			end
			covers[g] = seen;
		end
	end

	always_comb begin
		logic hit;
		for (int a = 0; a < NUM_GROUPS; a++) begin
			for (int b = 0; b < NUM_GROUPS; b++) begin
				hit = 1'b0;
				for (int s = 0; s < COLORS_PER_GROUP; s++) begin
					hit = hit | (first[a][s] && !eq[b][s]);
				end
				conflict[a*NUM_GROUPS+b] = hit;
			end
		end
	end

endmodule

// ----- rtl/core/tps_resolve.sv -----
// End-of-tile group choice from the cover and conflict flags.
module tps_resolve #(
	parameter int NUM_GROUPS = tps_pkg::NUM_GROUPS_DEF
) (
	input  logic [NUM_GROUPS-1:0]              covers,
	input  logic [NUM_GROUPS*NUM_GROUPS-1:0]   conflict,
	input  logic signed [tps_pkg::EXPL_W-1:0]  explicit_index,
	output tps_pkg::tps_result_t               result
);
	import tps_pkg::*;

	logic [NUM_GROUPS-1:0]  first_oh;
	logic                   any_cover;
	logic                   ambig;
	logic [GROUP_IDX_W-1:0] first_idx;
	logic                   expl_cover;
	logic                   expl_bad;

	always_comb begin
		logic seen;
		seen = 1'b0;
		first_idx = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			first_oh[g] = covers[g] && !seen;
			if (first_oh[g]) begin
				first_idx = GROUP_IDX_W'(g);
			end
			seen = seen | covers[g];
		end
		any_cover = seen;
	end

	// a later covering group that conflicts with the first one
	always_comb begin
		ambig = 1'b0;
		for (int a = 0; a < NUM_GROUPS; a++) begin
			for (int g = a + 1; g < NUM_GROUPS; g++) begin
				ambig = ambig | (first_oh[a] && covers[g] && conflict[a*NUM_GROUPS+g]);
			end
		end
	end

	always_comb begin
		expl_cover = 1'b0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (int'(explicit_index[GROUP_IDX_W-1:0]) == g) begin
				expl_cover = covers[g];
			end
		end
		expl_bad = explicit_index[EXPL_W-1]
			|| (int'(explicit_index[GROUP_IDX_W-1:0]) >= NUM_GROUPS);
	end

	always_comb begin
		if (explicit_index == EXPLICIT_AUTO) begin
			if (!any_cover) begin
				result.group_index = '0;
				result.status      = ST_NONE;
			end else begin
				result.group_index = first_idx;
				result.status      = ambig ? ST_AMBIG : ST_OK;
			end
		end else if (expl_bad) begin
			result.group_index = '0;
			result.status      = ST_MISSING;
		end else begin
			result.group_index = explicit_index[GROUP_IDX_W-1:0];
			result.status      = expl_cover ? ST_OK : ST_MISSING;
		end
	end

endmodule

// ----- rtl/core/tile_palette_selector_core.sv -----
// Top level of the tile palette selector: palette registers, tile state, handshake.
//
// One pixel item is taken per clock unless the input stalls. Each item is held in
// an input register, matched against all palette slots in parallel, and folded into
// the tile's cover and conflict flags; the item marked last produces one result,
// registered into the output register, and the flags return to their start values
// for the next tile. A result waiting on a stalled output holds back only the next
// last item; ordinary pixels keep flowing. The user must write palette registers
// only while the block is idle, via the configuration port; the block does not check.
module tile_palette_selector_core #(
	parameter  int NUM_GROUPS       = tps_pkg::NUM_GROUPS_DEF,
	parameter  int COLORS_PER_GROUP = tps_pkg::COLORS_PER_GROUP_DEF,
	localparam int REGS_PER_GROUP   = (COLORS_PER_GROUP + 1) / 2,
	localparam int NUM_REGS         = NUM_GROUPS * REGS_PER_GROUP,
	localparam int CFG_INDEX_W      = $clog2(NUM_REGS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [CFG_INDEX_W-1:0]            cfg_index,
	input  logic [tps_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              pixel_valid,
	output logic                              pixel_stall,
	input  logic [tps_pkg::COLOR_W-1:0]       pixel_color,
	input  logic signed [tps_pkg::EXPL_W-1:0] explicit_index,
	input  logic                              last_pixel,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [tps_pkg::GROUP_IDX_W-1:0]   group_index,
	output logic [1:0]                        status
);
	import tps_pkg::*;

	logic [NUM_GROUPS-1:0][COLORS_PER_GROUP-1:0][COLOR_W-1:0] palette_q;

	logic                     valid_s1;
	logic [COLOR_W-1:0]       color_s1;
	logic signed [EXPL_W-1:0] expl_s1;
	logic                     last_s1;

	logic [NUM_GROUPS-1:0]            covers_q;
	logic [NUM_GROUPS*NUM_GROUPS-1:0] conflict_q;
	logic [NUM_GROUPS-1:0]            pix_covers;
	logic [NUM_GROUPS*NUM_GROUPS-1:0] pix_conflict;
	logic [NUM_GROUPS-1:0]            covers_next;
	logic [NUM_GROUPS*NUM_GROUPS-1:0] conflict_next;

	tps_result_t res_next;
	tps_result_t res_q;
	logic        res_valid_q;

	logic advance;
	logic s1_fire;
	logic load_s1;
	logic out_fire;

	// palette registers, one per slot
	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
		for (genvar s = 0; s < COLORS_PER_GROUP; s++) begin : g_slot
			localparam int REG_IDX = g * REGS_PER_GROUP + s / 2;
			localparam int LO      = (s % 2) * COLOR_W;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					palette_q[g][s] <= '0;
				end else if (cfg_write && (cfg_index == CFG_INDEX_W'(REG_IDX))) begin
					palette_q[g][s] <= cfg_data[LO +: COLOR_W];
				end
			end
		end
	end

	assign out_fire    = res_valid_q && !result_stall;
	assign advance     = !last_s1 || !res_valid_q || !result_stall;
	assign s1_fire     = valid_s1 && advance;
	assign pixel_stall = valid_s1 && !advance;
	assign load_s1     = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && pixel_valid) begin
			color_s1 <= pixel_color;
			expl_s1  <= explicit_index;
			last_s1  <= last_pixel;
		end
	end

	tps_match #(
		.NUM_GROUPS      (NUM_GROUPS),
		.COLORS_PER_GROUP(COLORS_PER_GROUP)
	) u_match (
		.palette (palette_q),
		.color   (color_s1),
		.covers  (pix_covers),
		.conflict(pix_conflict)
	);

	assign covers_next   = covers_q & pix_covers;
	assign conflict_next = conflict_q | pix_conflict;

	tps_resolve #(
		.NUM_GROUPS(NUM_GROUPS)
	) u_resolve (
		.covers        (covers_next),
		.conflict      (conflict_next),
		.explicit_index(expl_s1),
		.result        (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			covers_q   <= '1;
			conflict_q <= '0;
		end else if (s1_fire) begin
			if (last_s1) begin
				covers_q   <= '1;
				conflict_q <= '0;
			end else begin
				covers_q   <= covers_next;
				conflict_q <= conflict_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (out_fire) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			res_q <= res_next;
		end
	end

	assign result_valid = res_valid_q;
	assign group_index  = res_q.group_index;
	assign status       = res_q.status;

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && last_s1) |=> res_valid_q)
		else $error("last item did not produce a result");

	a_tile_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && last_s1) |=> (covers_q == '1 && conflict_q == '0))
		else $error("tile state not cleared after last item");

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result_stall) |=> (!res_valid_q || $past(s1_fire && last_s1)))
		else $error("result repeated after delivery");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> (last_s1 && res_valid_q && result_stall))
		else $error("input stalled without a blocked result");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && result_stall) |=> (res_valid_q && $stable(res_q)))
		else $error("stalled result changed");

endmodule

// ----- test/tile_palette_selector_core_tb.sv -----
// Testbench of the tile palette selector core: directed table and random tiles against a predictor.
module tile_palette_selector_core_tb;
	import tps_pkg::*;

	localparam int NUM_G        = NUM_GROUPS_DEF;
	localparam int NUM_S        = COLORS_PER_GROUP_DEF;
	localparam int DRAIN_CYCLES = 4;
	localparam int NUM_DIR      = 24;
	localparam int RAND_PIXELS  = 475;

	localparam logic [31:0] CLR_A = 32'hFFFF_FFFF;
	localparam logic [31:0] CLR_B = 32'h0F0F_0F0F;
	localparam logic [31:0] CLR_C = 32'hA5A5_5A5A;
	localparam logic [31:0] CLR_D = 32'h0000_0000;

	typedef enum logic [2:0] {
		REG_G0_LO, REG_G0_HI, REG_G1_LO, REG_G1_HI,
		REG_G2_LO, REG_G2_HI, REG_G3_LO, REG_G3_HI
	} palette_reg_t;

	typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		palette_reg_t cfg_reg;
		logic [63:0]  cfg_val;
		logic [31:0]  color;
		logic [2:0]   expl;
		logic         last;
		logic         typed;
		tps_result_t  want;
	} stim_row_t;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                cfg_write      = 1'b0;
	logic [2:0]          cfg_index      = '0;
	logic [63:0]         cfg_data       = '0;
	logic                pixel_valid    = 1'b0;
	logic                pixel_stall;
	logic [31:0]         pixel_color    = '0;
	logic signed [2:0]   explicit_index = '0;
	logic                last_pixel     = 1'b0;
	logic                result_valid;
	logic                result_stall   = 1'b0;
	logic [1:0]          group_index;
	logic [1:0]          status;

	logic [31:0]            palette_q [NUM_G][NUM_S];
	logic [NUM_G-1:0]       tile_cover;
	logic [NUM_G*NUM_G-1:0] tile_clash;
	tps_result_t            pending_q [$];
	tps_result_t            head_r;
	stim_row_t              dir_rows [NUM_DIR];
	int                     fails         = 0;
	int                     send_gap_pct  = 0;
	int                     stall_pct     = 0;

	tile_palette_selector_core DUT (.*);

	always #4 clk = ~clk;

	initial begin
		#3200000;
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(negedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_q.size() == 0) begin
				fails++;
				$display("%0t unexpected result: expected none, actual group_index %0d status %0d",
					$time, group_index, status);
			end else begin
				head_r = pending_q.pop_front();
				if (group_index !== head_r.group_index) begin
					fails++;
					$display("%0t group_index mismatch: expected %0d, actual %0d",
						$time, head_r.group_index, group_index);
				end
				if (status !== head_r.status) begin
					fails++;
					$display("%0t status mismatch: expected %0d, actual %0d",
						$time, head_r.status, status);
				end
			end
		end
	end

	task automatic fold_pixel(input logic [31:0] c);
		logic [NUM_G-1:0] hit;
		hit = '0;
		for (int a = 0; a < NUM_G; a++) begin
			for (int s = 0; s < NUM_S; s++) begin
				if (!hit[a] && palette_q[a][s] == c) begin
					hit[a] = 1'b1;
					for (int b = 0; b < NUM_G; b++) begin
						if (palette_q[b][s] != c)
							tile_clash[a*NUM_G+b] = 1'b1;
					end
				end
			end
		end
		tile_cover &= hit;
	endtask

	task automatic predict_pixel(input logic [31:0] c, input logic [2:0] ex, input logic last,
			output logic emits, output tps_result_t r);
		logic found;
		int   first;
		fold_pixel(c);
		emits = last;
		r.group_index = '0;
		r.status = ST_OK;
		if (!last)
			return;
		if (ex != EXPLICIT_AUTO) begin
			if ($signed(ex) < 0 || int'($signed(ex)) >= NUM_G) begin
				r.status = ST_MISSING;
			end else begin
				r.group_index = ex[1:0];
				r.status = tile_cover[ex[1:0]] ? ST_OK : ST_MISSING;
			end
		end else begin
			found = 1'b0;
			first = 0;
			for (int g = 0; g < NUM_G; g++) begin
				if (tile_cover[g]) begin
					if (!found) begin
						found = 1'b1;
						first = g;
					end else if (tile_clash[first*NUM_G+g]) begin
						r.status = ST_AMBIG;
					end
				end
			end
			if (!found)
				r.status = ST_NONE;
			else
				r.group_index = first[1:0];
		end
		tile_cover = '1;
		tile_clash = '0;
	endtask

	task automatic send_pixel(input logic [31:0] c, input logic [2:0] ex, input logic last,
			input logic typed, input tps_result_t want);
		logic        taken;
		logic        emits;
		tps_result_t r;
		cfg_write <= 1'b0;
		while ($urandom_range(99) < send_gap_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid    <= 1'b1;
		pixel_color    <= c;
		explicit_index <= ex;
		last_pixel     <= last;
		do begin
			@(negedge clk);
			taken = !pixel_stall;
			@(posedge clk);
		end while (!taken);
		predict_pixel(c, ex, last, emits, r);
		if (emits)
			pending_q.push_back(typed ? want : r);
	endtask

	// hold until every result is out and the pipeline has drained
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		cfg_write   <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic palette_write(input palette_reg_t idx, input logic [63:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		palette_q[int'(idx) / 2][(int'(idx) % 2) * 2]     = val[31:0];
		palette_q[int'(idx) / 2][(int'(idx) % 2) * 2 + 1] = val[63:32];
	endtask

	task automatic reprogram_random();
		logic [31:0] pool [6];
		logic [31:0] slot [NUM_S];
		int          roll;
		for (int p = 0; p < 6; p++) begin
			roll = $urandom_range(9);
			pool[p] = (roll == 0) ? '1 : (roll == 1) ? '0 : $urandom;
		end
		wait_idle();
		for (int g = 0; g < NUM_G; g++) begin
			roll = $urandom_range(3);
			for (int s = 0; s < NUM_S; s++)
				slot[s] = (roll == 0 && g > 0) ? palette_q[g-1][s] : pool[$urandom_range(5)];
			palette_write(palette_reg_t'(2 * g), {slot[1], slot[0]});
			palette_write(palette_reg_t'(2 * g + 1), {slot[3], slot[2]});
		end
	endtask

	task automatic run_random(input int n_pixels);
		int          sent;
		int          since_cfg;
		int          len;
		int          tgt;
		int          roll;
		logic [31:0] c;
		logic [2:0]  ex;
		logic        last;
		sent = 0;
		since_cfg = 120;
		while (sent < n_pixels) begin
			if (since_cfg >= 120) begin
				reprogram_random();
				since_cfg = 0;
			end
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
			tgt = $urandom_range(NUM_G - 1);
			for (int i = 0; i < len; i++) begin
				if (i > 0 && $urandom_range(59) == 0) begin
					wait_idle();
					palette_write(palette_reg_t'($urandom_range(7)),
						{palette_q[$urandom_range(NUM_G-1)][$urandom_range(NUM_S-1)], $urandom});
				end
				roll = $urandom_range(99);
				if (roll < 80)
					c = palette_q[tgt][$urandom_range(NUM_S - 1)];
				else if (roll < 92)
					c = palette_q[$urandom_range(NUM_G - 1)][$urandom_range(NUM_S - 1)];
				else
					c = $urandom;
				last = (i == len - 1);
				roll = $urandom_range(99);
				if (!last)
					ex = 3'($urandom_range(7));
				else if (roll < 55)
					ex = EXPLICIT_AUTO;
				else if (roll < 90)
					ex = 3'($urandom_range(NUM_G - 1));
				else
					ex = 3'($urandom_range(6, 4));
				send_pixel(c, ex, last, 1'b0, '0);
			end
			sent += len;
			since_cfg += len;
		end
	endtask

	initial begin
		for (int g = 0; g < NUM_G; g++)
			for (int s = 0; s < NUM_S; s++)
				palette_q[g][s] = '0;
		tile_cover = '1;
		tile_clash = '0;
		dir_rows = '{
			'{ROW_PIXEL, REG_G0_LO, 64'd0, CLR_D, EXPLICIT_AUTO, 1'b1, 1'b1, '{2'd0, ST_OK}},
			'{ROW_PIXEL, REG_G0_LO, 64'd0, CLR_A, EXPLICIT_AUTO, 1'b1, 1'b1, '{2'd0, ST_NONE}},
			'{ROW_PIXEL, REG_G0_LO, 64'd0, CLR_D, 3'b011, 1'b0, 1'b0, '{2'd0, ST_OK}},
			'{ROW_PIXEL, REG_G0_LO, 64'd0, CLR_D, 3'b011, 1'b1, 1'b1, '{2'd3, ST_OK}},
			'{ROW_PIXEL, REG_G0_LO, 64'd0, 32'd5, 3'b010, 1'b1, 1'b1, '{2'd2, ST_MISSING}},
			'{ROW_PIXEL, REG_G0_LO, 64'd0, CLR_D, 3'b100, 1'b1, 1'b1, '{2'd0, ST_MISSING}},
			'{ROW_PIXEL, REG_G0_LO, 64'd0, CLR_D, 3'b110, 1'b1, 1'b1, '{2'd0, ST_MISSING}},
			'{ROW_PIXEL, REG_G0_LO, 64'd0, CLR_D, 3'b101, 1'b1, 1'b1, '{2'd0, ST_MISSING}},
			'{ROW_CFG, REG_G0_LO, {CLR_B, CLR_A}, CLR_D, 3'b000, 1'b0, 1'b0, '{2'd0, ST_OK}},
			'{ROW_CFG, REG_G0_HI, {CLR_D, CLR_C}, CLR_D, 3'b000, 1'b0, 1'b0, '{2'd0, ST_OK}},
			'{ROW_CFG, REG_G1_LO, {CLR_B, CLR_A}, CLR_D, 3'b000, 1'b0, 1'b0, '{2'd0, ST_OK}},
			'{ROW_CFG, REG_G1_HI, {CLR_D, CLR_C}, CLR_D, 3'b000, 1'b0, 1'b0, '{2'd0, ST_OK}},
			'{ROW_CFG, REG_G2_LO, {CLR_A, CLR_B}, CLR_D, 3'b000, 1'b0, 1'b0, '{2'd0, ST_OK}},
			'{ROW_CFG, REG_G2_HI, {CLR_D, CLR_C}, CLR_D, 3'b000, 1'b0, 1'b0, '{2'd0, ST_OK}},
			'{ROW_CFG, REG_G3_LO, {CLR_D, CLR_D}, CLR_D, 3'b000, 1'b0, 1'b0, '{2'd0, ST_OK}},
			'{ROW_CFG, REG_G3_HI, {CLR_A, CLR_A}, CLR_D, 3'b000, 1'b0, 1'b0, '{2'd0, ST_OK}},
			'{ROW_PIXEL, REG_G0_LO, 64'd0, CLR_C, EXPLICIT_AUTO, 1'b1, 1'b0, '{2'd0, ST_OK}},
			'{ROW_PIXEL, REG_G0_LO, 64'd0, CLR_A, EXPLICIT_AUTO, 1'b1, 1'b0, '{2'd0, ST_OK}},
			'{ROW_PIXEL, REG_G0_LO, 64'd0, CLR_D, 3'b000, 1'b0, 1'b0, '{2'd0, ST_OK}},
			'{ROW_PIXEL, REG_G0_LO, 64'd0, CLR_C, 3'b001, 1'b1, 1'b1, '{2'd1, ST_OK}},
			'{ROW_PIXEL, REG_G0_LO, 64'd0, CLR_C, 3'b000, 1'b0, 1'b0, '{2'd0, ST_OK}},
			'{ROW_CFG, REG_G0_HI, {CLR_D, CLR_B}, CLR_D, 3'b000, 1'b0, 1'b0, '{2'd0, ST_OK}},
			'{ROW_PIXEL, REG_G0_LO, 64'd0, CLR_C, EXPLICIT_AUTO, 1'b1, 1'b0, '{2'd0, ST_OK}},
			'{ROW_PIXEL, REG_G0_LO, 64'd0, 32'h1234_5678, EXPLICIT_AUTO, 1'b1, 1'b1,
				'{2'd0, ST_NONE}}
		};
		send_gap_pct = 16;
		stall_pct = 70;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_idle();
				palette_write(dir_rows[i].cfg_reg, dir_rows[i].cfg_val);
			end else begin
				send_pixel(dir_rows[i].color, dir_rows[i].expl, dir_rows[i].last,
					dir_rows[i].typed, dir_rows[i].want);
			end
		end
		run_random(RAND_PIXELS);
		send_gap_pct = 70;
		stall_pct = 16;
		run_random(RAND_PIXELS);
		send_gap_pct = 0;
		stall_pct = 0;
		run_random(RAND_PIXELS);
		wait_idle();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
